// ----- hdl/grid_astar_next_step_core_defines.svh -----
// Assertion helpers used by the block's top-level RTL.
`ifndef GRID_ASTAR_NEXT_STEP_CORE_DEFINES_SVH
`define GRID_ASTAR_NEXT_STEP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GANS_CHK_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GANS_CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/gans_pkg.sv -----
`default_nettype none

package gans_pkg;

    // Controller states.
    typedef enum logic [3:0] {
        CS_INIT,
        CS_IDLE,
        CS_DEC,
        CS_CLR,
        CS_SEED,
        CS_SCAN,
        CS_SCAN_W,
        CS_PICK,
        CS_NB_RD,
        CS_NB_CHK,
        CS_TR_RD,
        CS_TR_CHK,
        CS_DONE
    } t_state;

    // Per-cell search status.
    typedef enum logic [1:0] {
        ND_FREE,
        ND_OPEN,
        ND_DONE
    } t_node;

    // Neighbour directions in the order they are tried.
    typedef enum logic [1:0] {
        DIR_XP,
        DIR_XN,
        DIR_YP,
        DIR_YN
    } t_dir;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic cnt_clr;
        logic map_clr;
        logic map_wr;
        logic clr_step;
        logic seed;
        logic scan_start;
        logic scan_rd;
        logic close;
        logic dir_inc;
        logic nb_upd;
        logic tr_start;
        logic tr_rd;
        logic tr_step;
        logic res_zero;
        logic res_fail;
        logic res_found;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_last_map;
        logic cnt_last_tab;
        logic op_query;
        logic best_valid;
        logic best_goal;
        logic best_start;
        logic nb_in;
        logic dir_last;
        logic tr_hit;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- hdl/grid_astar_next_step_core.sv -----
// Write item: written to the map cell in the decode state, then an all-zero result is loaded.
// Query: the node table of max(GRID_COLS,16)*max(GRID_ROWS,16) entries is cleared; then each
// expanded node comes from a full table scan and has its four neighbours checked in turn, and
// the path is traced back from the goal; all of it runs through the one node memory port.
// One item at a time; the result register frees the input side while a result waits.
// Synchronous active-low reset; afterwards a clear pass over all GRID_COLS*GRID_ROWS map cells
// marks every cell blocked, during which no item is taken.
`default_nettype none
`include "grid_astar_next_step_core_defines.svh"

module grid_astar_next_step_core #(
    parameter int GRID_COLS = 16,
    parameter int GRID_ROWS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x[3:0], pos_y[7:4], walkable[8], goal_x[12:9], goal_y[16:13], zero pad
    input  logic [23:0] s_axis_tdata,
    // op[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // next_x[3:0], next_y[7:4], found[8], path_steps[16:9], zero pad
    output logic [23:0] m_axis_tdata
);
    import gans_pkg::*;

    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [3:0] w_next_x;
    logic [3:0] w_next_y;
    logic       w_found;
    logic [7:0] w_steps;

    gans_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    gans_dp #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_op         (s_axis_tuser),
        .i_pos_x      (s_axis_tdata[3:0]),
        .i_pos_y      (s_axis_tdata[7:4]),
        .i_walkable   (s_axis_tdata[8]),
        .i_goal_x     (s_axis_tdata[12:9]),
        .i_goal_y     (s_axis_tdata[16:13]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_next_x     (w_next_x),
        .o_next_y     (w_next_y),
        .o_found      (w_found),
        .o_path_steps (w_steps)
    );

    assign m_axis_tdata = {7'b0, w_steps, w_found, w_next_y, w_next_x};

    // An accepted beat starts work, so the input side closes on the next cycle.
    `GANS_CHK_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A result is only loaded when the output register is empty or draining.
    `GANS_CHK_SAME(a_load_when_free, i_clk, i_rst_n, w_cmd.out_load, !m_axis_tvalid || m_axis_tready)
    // A new result appears only after the controller loaded one.
    `GANS_CHK_SAME(a_valid_from_load, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(w_cmd.out_load))

endmodule

`default_nettype wire

// ----- hdl/gans_ctrl.sv -----
`default_nettype none

module gans_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  gans_pkg::t_sts  i_sts,
    output gans_pkg::t_cmd  o_cmd
);
    import gans_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            CS_INIT: begin
                o_cmd.map_clr = 1'b1;
                if (i_sts.cnt_last_map) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = CS_IDLE;
                end
            end
            CS_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = CS_DEC;
                end
            end
            CS_DEC: begin
                if (i_sts.op_query) begin
                    n_state = CS_CLR;
                end else begin
                    o_cmd.map_wr   = 1'b1;
                    o_cmd.res_zero = 1'b1;
                    n_state        = CS_DONE;
                end
            end
            CS_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.cnt_last_tab) begin
                    n_state = CS_SEED;
                end
            end
            CS_SEED: begin
                o_cmd.seed       = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state          = CS_SCAN;
            end
            CS_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.cnt_last_tab) begin
                    n_state = CS_SCAN_W;
                end
            end
            CS_SCAN_W: begin
                n_state = CS_PICK;
            end
            CS_PICK: begin
                if (!i_sts.best_valid) begin
                    o_cmd.res_fail = 1'b1;
                    n_state        = CS_DONE;
                end else if (i_sts.best_goal) begin
                    if (i_sts.best_start) begin
                        o_cmd.res_fail = 1'b1;
                        n_state        = CS_DONE;
                    end else begin
                        o_cmd.tr_start = 1'b1;
                        n_state        = CS_TR_RD;
                    end
                end else begin
                    o_cmd.close = 1'b1;
                    n_state     = CS_NB_RD;
                end
            end
            CS_NB_RD: begin
                if (i_sts.nb_in) begin
                    n_state = CS_NB_CHK;
                end else if (i_sts.dir_last) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = CS_SCAN;
                end else begin
                    o_cmd.dir_inc = 1'b1;
                end
            end
            CS_NB_CHK: begin
                o_cmd.nb_upd = 1'b1;
                if (i_sts.dir_last) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = CS_SCAN;
                end else begin
                    o_cmd.dir_inc = 1'b1;
                    n_state       = CS_NB_RD;
                end
            end
            CS_TR_RD: begin
                o_cmd.tr_rd = 1'b1;
                n_state     = CS_TR_CHK;
            end
            CS_TR_CHK: begin
                if (i_sts.tr_hit) begin
                    o_cmd.res_found = 1'b1;
                    n_state         = CS_DONE;
                end else begin
                    o_cmd.tr_step = 1'b1;
                    n_state       = CS_TR_RD;
                end
            end
            CS_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/gans_dp.sv -----
`default_nettype none

module gans_dp #(
    parameter int GRID_COLS = 16,
    parameter int GRID_ROWS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gans_pkg::t_cmd  i_cmd,
    output gans_pkg::t_sts  o_sts,
    input  logic            i_op,
    input  logic [3:0]      i_pos_x,
    input  logic [3:0]      i_pos_y,
    input  logic            i_walkable,
    input  logic [3:0]      i_goal_x,
    input  logic [3:0]      i_goal_y,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [3:0]      o_next_x,
    output logic [3:0]      o_next_y,
    output logic            o_found,
    output logic [7:0]      o_path_steps
);
    import gans_pkg::*;

    localparam int TAB_W = (GRID_COLS > 16) ? GRID_COLS : 16;
    localparam int TAB_H = (GRID_ROWS > 16) ? GRID_ROWS : 16;
    localparam int TAB_N = TAB_W * TAB_H;
    localparam int MAP_N = GRID_COLS * GRID_ROWS;
    localparam int NW    = $clog2(TAB_N);
    localparam int XW    = $clog2(TAB_W);
    localparam int YW    = $clog2(TAB_H);
    localparam int MW    = $clog2(MAP_N);
    localparam int CW    = NW + 1;
    localparam int FW    = NW + 2;
    localparam logic [XW:0]   LIM_X    = GRID_COLS[XW:0];
    localparam logic [YW:0]   LIM_Y    = GRID_ROWS[YW:0];
    localparam logic [NW-1:0] LAST_TAB = NW'(TAB_N - 1);
    localparam logic [NW-1:0] LAST_MAP = NW'(MAP_N - 1);
    localparam logic [XW-1:0] LAST_X   = XW'(TAB_W - 1);

    // Item registers.
    logic          r_op;
    logic [3:0]    r_sx0;
    logic [3:0]    r_sy0;
    logic          r_wb;
    logic [3:0]    r_gx;
    logic [3:0]    r_gy;

    // Sweep counter and scan position.
    logic [NW-1:0] r_cnt;
    logic [XW-1:0] r_scx;
    logic [YW-1:0] r_scy;
    logic          r_pv;
    logic [NW-1:0] r_pidx;
    logic [XW-1:0] r_pcx;
    logic [YW-1:0] r_pcy;

    // Best open node of the current scan.
    logic          r_bvalid;
    logic [NW-1:0] r_bidx;
    logic [XW-1:0] r_bx;
    logic [YW-1:0] r_by;
    logic [FW-1:0] r_bf;
    logic [CW-1:0] r_bo;
    logic [CW-1:0] r_bcost;

    // Expansion and trace state.
    t_dir          r_dir;
    logic [CW-1:0] r_ins;
    logic [NW-1:0] r_tn;
    logic [XW-1:0] r_tx;
    logic [YW-1:0] r_ty;

    // Staged result and output register.
    logic [3:0]    r_rx;
    logic [3:0]    r_ry;
    logic          r_rf;
    logic [7:0]    r_rs;
    logic          r_ov;
    logic [3:0]    r_ox;
    logic [3:0]    r_oy;
    logic          r_of;
    logic [7:0]    r_os;

    // Memories and their registered read data.
    logic          mem_map  [MAP_N];
    t_node         mem_st   [TAB_N];
    logic [CW-1:0] mem_cost [TAB_N];
    t_dir          mem_par  [TAB_N];
    logic [CW-1:0] mem_ord  [TAB_N];
    logic          r_map_rd;
    t_node         r_st_rd;
    logic [CW-1:0] r_cost_rd;
    t_dir          r_par_rd;
    logic [CW-1:0] r_ord_rd;

    logic [NW-1:0] w_si;
    logic [XW-1:0] w_gx;
    logic [YW-1:0] w_gy;
    logic          w_win;
    logic [MW-1:0] w_wmi;
    logic [XW:0]   w_nx;
    logic [YW:0]   w_ny;
    logic          w_nb_in;
    logic [NW-1:0] w_ni;
    logic [MW-1:0] w_mi;
    logic [NW-1:0] w_ra;
    logic [XW-1:0] w_hx;
    logic [YW-1:0] w_hy;
    logic [FW-1:0] w_f;
    logic          w_better;
    logic [CW-1:0] w_ng;
    logic [XW-1:0] w_tpx;
    logic [YW-1:0] w_tpy;
    logic [NW-1:0] w_tp;
    logic          map_we;
    logic [MW-1:0] map_wa;
    logic          map_wd;
    logic [NW-1:0] nd_wa;
    logic          st_we;
    t_node         st_wd;
    logic          cost_we;
    logic [CW-1:0] cost_wd;
    logic          par_we;
    logic          ord_we;
    logic [CW-1:0] ord_wd;
    logic          w_new;
    logic          w_lower;

    // Addresses of start, write target and neighbour.
    assign w_si  = NW'(r_sy0) * NW'(TAB_W) + NW'(r_sx0);
    assign w_gx  = XW'(r_gx);
    assign w_gy  = YW'(r_gy);
    assign w_win = (7'(r_sx0) < 7'(GRID_COLS)) && (7'(r_sy0) < 7'(GRID_ROWS));
    assign w_wmi = MW'(r_sy0) * MW'(GRID_COLS) + MW'(r_sx0);

    always_comb begin
        w_nx = {1'b0, r_bx};
        w_ny = {1'b0, r_by};
        case (r_dir)
            DIR_XP:  w_nx = {1'b0, r_bx} + 1'b1;
            DIR_XN:  w_nx = {1'b0, r_bx} - 1'b1;
            DIR_YP:  w_ny = {1'b0, r_by} + 1'b1;
            DIR_YN:  w_ny = {1'b0, r_by} - 1'b1;
            default: w_nx = {1'b0, r_bx};
        endcase
    end

    // A step below zero wraps to a large value and fails the bound check.
    assign w_nb_in = (w_nx < LIM_X) && (w_ny < LIM_Y);
    assign w_ni    = NW'(w_ny[YW-1:0]) * NW'(TAB_W) + NW'(w_nx[XW-1:0]);
    assign w_mi    = MW'(w_ny[YW-1:0]) * MW'(GRID_COLS) + MW'(w_nx[XW-1:0]);

    // Node memory read address.
    always_comb begin
        if (i_cmd.scan_rd) begin
            w_ra = r_cnt;
        end else if (i_cmd.tr_rd) begin
            w_ra = r_tn;
        end else begin
            w_ra = w_ni;
        end
    end

    // f of the entry coming out of the scan read.
    assign w_hx = (r_pcx > w_gx) ? (r_pcx - w_gx) : (w_gx - r_pcx);
    assign w_hy = (r_pcy > w_gy) ? (r_pcy - w_gy) : (w_gy - r_pcy);
    assign w_f  = FW'(r_cost_rd) + FW'(w_hx) + FW'(w_hy);
    assign w_better = r_pv && (r_st_rd == ND_OPEN) &&
                      (!r_bvalid || (w_f < r_bf) || ((w_f == r_bf) && (r_ord_rd < r_bo)));

    // Neighbour update decision.
    assign w_ng    = r_bcost + 1'b1;
    assign w_new   = r_map_rd && (r_st_rd == ND_FREE);
    assign w_lower = r_map_rd && (r_st_rd == ND_OPEN) && (w_ng < r_cost_rd);

    // Parent of the traced node.
    always_comb begin
        w_tpx = r_tx;
        w_tpy = r_ty;
        case (r_par_rd)
            DIR_XP:  w_tpx = r_tx - 1'b1;
            DIR_XN:  w_tpx = r_tx + 1'b1;
            DIR_YP:  w_tpy = r_ty - 1'b1;
            DIR_YN:  w_tpy = r_ty + 1'b1;
            default: w_tpx = r_tx;
        endcase
    end
    assign w_tp = NW'(w_tpy) * NW'(TAB_W) + NW'(w_tpx);

    // Write ports of the memories.
    always_comb begin
        map_we  = 1'b0;
        map_wa  = w_wmi;
        map_wd  = r_wb;
        nd_wa   = w_ni;
        st_we   = 1'b0;
        st_wd   = ND_FREE;
        cost_we = 1'b0;
        cost_wd = w_ng;
        par_we  = 1'b0;
        ord_we  = 1'b0;
        ord_wd  = r_ins;
        if (i_cmd.map_clr) begin
            map_we = 1'b1;
            map_wa = MW'(r_cnt);
            map_wd = 1'b0;
        end else if (i_cmd.map_wr) begin
            map_we = w_win;
        end
        if (i_cmd.clr_step) begin
            nd_wa = r_cnt;
            st_we = 1'b1;
        end else if (i_cmd.seed) begin
            nd_wa   = w_si;
            st_we   = 1'b1;
            st_wd   = ND_OPEN;
            cost_we = 1'b1;
            cost_wd = '0;
            ord_we  = 1'b1;
            ord_wd  = '0;
        end else if (i_cmd.close) begin
            nd_wa = r_bidx;
            st_we = 1'b1;
            st_wd = ND_DONE;
        end else if (i_cmd.nb_upd) begin
            st_we   = w_new;
            st_wd   = ND_OPEN;
            cost_we = w_new || w_lower;
            par_we  = w_new || w_lower;
            ord_we  = w_new;
        end
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem_map[map_wa] <= map_wd;
        end
        r_map_rd <= mem_map[w_mi];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            mem_st[nd_wa] <= st_wd;
        end
        if (cost_we) begin
            mem_cost[nd_wa] <= cost_wd;
        end
        if (par_we) begin
            mem_par[nd_wa] <= r_dir;
        end
        if (ord_we) begin
            mem_ord[nd_wa] <= ord_wd;
        end
        r_st_rd   <= mem_st[w_ra];
        r_cost_rd <= mem_cost[w_ra];
        r_par_rd  <= mem_par[w_ra];
        r_ord_rd  <= mem_ord[w_ra];
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_sx0 <= i_pos_x;
            r_sy0 <= i_pos_y;
            r_wb  <= i_walkable;
            r_gx  <= i_goal_x;
            r_gy  <= i_goal_y;
        end
    end

    // Sweep counter, scan pipeline and best tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_scx    <= '0;
            r_scy    <= '0;
            r_pv     <= 1'b0;
            r_bvalid <= 1'b0;
        end else begin
            r_pv <= i_cmd.scan_rd;
            if (i_cmd.cnt_clr || i_cmd.scan_start) begin
                r_cnt <= '0;
                r_scx <= '0;
                r_scy <= '0;
            end else if (i_cmd.map_clr || i_cmd.clr_step || i_cmd.scan_rd) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_scx == LAST_X) begin
                    r_scx <= '0;
                    r_scy <= r_scy + 1'b1;
                end else begin
                    r_scx <= r_scx + 1'b1;
                end
            end
            if (i_cmd.scan_start) begin
                r_bvalid <= 1'b0;
            end else if (w_better) begin
                r_bvalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_cnt;
        r_pcx  <= r_scx;
        r_pcy  <= r_scy;
        if (w_better) begin
            r_bidx  <= r_pidx;
            r_bx    <= r_pcx;
            r_by    <= r_pcy;
            r_bf    <= w_f;
            r_bo    <= r_ord_rd;
            r_bcost <= r_cost_rd;
        end
    end

    // Direction, insertion counter and trace pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.close) begin
            r_dir <= DIR_XP;
        end else if (i_cmd.dir_inc) begin
            r_dir <= t_dir'(2'(r_dir) + 2'd1);
        end
        if (i_cmd.seed) begin
            r_ins <= CW'(1);
        end else if (i_cmd.nb_upd && w_new) begin
            r_ins <= r_ins + 1'b1;
        end
        if (i_cmd.tr_start) begin
            r_tn <= r_bidx;
            r_tx <= r_bx;
            r_ty <= r_by;
        end else if (i_cmd.tr_step) begin
            r_tn <= w_tp;
            r_tx <= w_tpx;
            r_ty <= w_tpy;
        end
    end

    // Result staging.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_zero) begin
            r_rx <= '0;
            r_ry <= '0;
            r_rf <= 1'b0;
            r_rs <= '0;
        end else if (i_cmd.res_fail) begin
            r_rx <= r_sx0;
            r_ry <= r_sy0;
            r_rf <= 1'b0;
            r_rs <= '0;
        end else if (i_cmd.res_found) begin
            r_rx <= r_tx[3:0];
            r_ry <= r_ty[3:0];
            r_rf <= 1'b1;
            r_rs <= (r_bcost > CW'(255)) ? 8'hFF : r_bcost[7:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ox <= r_rx;
            r_oy <= r_ry;
            r_of <= r_rf;
            r_os <= r_rs;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_next_x     = r_ox;
    assign o_next_y     = r_oy;
    assign o_found      = r_of;
    assign o_path_steps = r_os;

    // Status to the controller.
    assign o_sts.cnt_last_map = (r_cnt == LAST_MAP);
    assign o_sts.cnt_last_tab = (r_cnt == LAST_TAB);
    assign o_sts.op_query     = r_op;
    assign o_sts.best_valid   = r_bvalid;
    assign o_sts.best_goal    = (r_bx == w_gx) && (r_by == w_gy);
    assign o_sts.best_start   = (r_bidx == w_si);
    assign o_sts.nb_in        = w_nb_in;
    assign o_sts.dir_last     = (r_dir == DIR_YN);
    assign o_sts.tr_hit       = (w_tp == w_si);
    assign o_sts.out_free     = !r_ov || i_out_ready;

endmodule

`default_nettype wire
